@@ sv/csl_pkg.sv @@
// Shared constants and types for the curvature speed limiter.
package csl_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// log2 datapath: fraction bits, and normalise plus squaring stages
	localparam int LOG_FRAC = 28;
	localparam int LOG_LAT  = LOG_FRAC + 2;

	// 0.3333 * ln 2 in Q0.32
	localparam logic [29:0] K_LN2_THIRD = 30'd992248922;

	localparam logic [30:0]        RST_YMAX  = 31'd32768;
	localparam logic [30:0]        RST_TAU   = 31'd65536;
	localparam logic [30:0]        RST_DIST  = 31'd327680;
	localparam logic [30:0]        RST_RATIO = 31'd262144;
	localparam logic signed [31:0] RST_VMIN  = 32'sd0;

	typedef enum logic [2:0] {
		REG_YMAX  = 3'd0,
		REG_TAU   = 3'd1,
		REG_DIST  = 3'd2,
		REG_RATIO = 3'd3,
		REG_VMIN  = 3'd4
	} cfg_reg_t;

endpackage

@@ sv/csl_delay.sv @@
// Fixed-length register line used to line up words between datapath branches.
module csl_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	generate
		if (DEPTH == 0) begin : g_none
			assign dout = din;
		end else begin : g_line
			logic [WIDTH-1:0] tap_q [DEPTH];

			always_ff @(posedge clk) begin
				tap_q[0] <= din;
				for (int i = 1; i < DEPTH; i++) begin
					tap_q[i] <= tap_q[i-1];
				end
			end

			assign dout = tap_q[DEPTH-1];
		end
	endgenerate

endmodule

@@ sv/csl_divu.sv @@
// Pipelined restoring divider: one quotient bit per stage.
module csl_divu #(
	parameter int QW = 32,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,   // upper dividend part, below den_in
	input  logic [QW-1:0] num_in,   // dividend bits brought down, msb first
	input  logic [DW-1:0] den_in,
	output logic [QW-1:0] quot
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] num_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	generate
		for (genvar i = 0; i < QW; i++) begin : g_stage
			logic [DW-1:0] rem_p;
			logic [DW-1:0] den_p;
			logic [QW-1:0] num_p;
			logic [QW-1:0] quo_p;
			logic [DW:0]   trial;
			logic          ge;

			if (i == 0) begin : g_first
				assign rem_p = rem_in;
				assign den_p = den_in;
				assign num_p = num_in;
				assign quo_p = '0;
			end else begin : g_next
				assign rem_p = rem_s[i-1];
				assign den_p = den_s[i-1];
				assign num_p = num_s[i-1];
				assign quo_p = quo_s[i-1];
			end

			assign trial = {rem_p, num_p[QW-1]};
			assign ge    = trial >= {1'b0, den_p};

			always_ff @(posedge clk) begin
				rem_s[i] <= ge ? DW'(trial - {1'b0, den_p}) : DW'(trial);
				num_s[i] <= num_p << 1;
				den_s[i] <= den_p;
				quo_s[i] <= {quo_p[QW-2:0], ge};
			end
		end
	endgenerate

	assign quot = quo_s[QW-1];

endmodule

@@ sv/csl_isqrt.sv @@
// Pipelined integer square root of a 62-bit value, two radicand bits per stage.
module csl_isqrt (
	input  logic        clk,
	input  logic [61:0] val,
	output logic [30:0] root
);

	localparam int STEPS = 32;

	logic [62:0] v_s   [STEPS];
	logic [62:0] res_s [STEPS];

	generate
		for (genvar k = 0; k < STEPS; k++) begin : g_step
			localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
			logic [62:0] v_p;
			logic [62:0] res_p;
			logic [62:0] trial;
			logic        ge;

			if (k == 0) begin : g_first
				assign v_p   = 63'(val);
				assign res_p = '0;
			end else begin : g_next
				assign v_p   = v_s[k-1];
				assign res_p = res_s[k-1];
			end

			assign trial = res_p + BIT;
			assign ge    = v_p >= trial;

			always_ff @(posedge clk) begin
				v_s[k]   <= ge ? v_p - trial : v_p;
				res_s[k] <= ge ? (res_p >> 1) + BIT : res_p >> 1;
			end
		end
	endgenerate

	assign root = res_s[STEPS-1][30:0];

endmodule

@@ sv/csl_log2.sv @@
// Pipelined log2: msb position, normalise, then one squaring per fraction bit.
module csl_log2 import csl_pkg::*; (
	input  logic                clk,
	input  logic [31:0]         x,
	output logic [LOG_FRAC+4:0] lg
);

	logic [4:0]  msb;
	logic [31:0] xa_s;
	logic [4:0]  ea_s;
	logic [31:0] mb_s;
	logic [4:0]  eb_s;

	logic [31:0]         m_s [LOG_FRAC];
	logic [LOG_FRAC-1:0] f_s [LOG_FRAC];
	logic [4:0]          e_s [LOG_FRAC];

	always_comb begin
		msb = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				msb = 5'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		xa_s <= x;
		ea_s <= msb;
		mb_s <= xa_s << (5'd31 - ea_s);
		eb_s <= ea_s;
	end

	generate
		for (genvar j = 0; j < LOG_FRAC; j++) begin : g_sq
			logic [31:0]         m_p;
			logic [LOG_FRAC-1:0] f_p;
			logic [4:0]          e_p;
			logic [63:0]         sq;

			if (j == 0) begin : g_first
				assign m_p = mb_s;
				assign f_p = '0;
				assign e_p = eb_s;
			end else begin : g_next
				assign m_p = m_s[j-1];
				assign f_p = f_s[j-1];
				assign e_p = e_s[j-1];
			end

			assign sq = m_p * m_p;

			// mantissa squared reaching 2 gives a one bit and a renormalise
			always_ff @(posedge clk) begin
				m_s[j] <= sq[63] ? sq[63:32] : sq[62:31];
				f_s[j] <= {f_p[LOG_FRAC-2:0], sq[63]};
				e_s[j] <= e_p;
			end
		end
	endgenerate

	assign lg = {e_s[LOG_FRAC-1], f_s[LOG_FRAC-1]};

endmodule

@@ sv/curvature_speed_limiter.sv @@
// limited_speed and done are registered and appear together for each word taken.
// Throughput: one word per clock; busy stays low once out of reset.
// The latency is set by the 62-stage curvature divider followed by the 32-stage root.
// Results are strobed by done for one cycle; the receiver cannot stall.
// Reset clears all valid bits, loads register defaults and sets busy till a clock.
module curvature_speed_limiter import csl_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] requested_speed,
	input  logic signed [31:0] present_curvature,
	input  logic signed [31:0] upcoming_curvature,
	input  logic signed [31:0] lateral_deviation,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	output logic               done,
	output logic signed [31:0] limited_speed
);

	localparam int F        = FRAC_BITS;
	localparam int NW       = 31 + 3 * F;
	localparam int NXW      = (NW > 63) ? NW : 63;
	localparam int TOPW     = NXW - 62;
	localparam int QA       = 2 * F + 1;
	localparam int AW       = 2 * F + 2;
	localparam int TW       = F + 3;
	localparam int HALF     = F + 1;
	localparam int PW       = 31 + AW;
	localparam int HW       = (PW - 32 > 34) ? PW - 32 : 34;
	localparam int LOGK_LAT = LOG_LAT + 2;
	localparam int LAT_J    = (LOGK_LAT > QA) ? LOGK_LAT : QA;
	localparam int CURV_LAT = 2 + 62 + 32;
	localparam int DEV_LAT  = LAT_J + 37;
	localparam int PIPE_DEPTH = CURV_LAT + 3;

	localparam logic [QA-1:0] A_NUM   = QA'(1) << (2 * F);
	localparam logic [32:0]   Q2_CAP  = 33'h0_8000_0000;

	// configuration
	logic [30:0]        ymax_q, tau_q, dist_q, ratio_q;
	logic signed [31:0] vmin_q;
	logic [30:0]        ymax_e, tau_e, ratio_e;
	logic [32:0]        den3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ymax_q  <= RST_YMAX;
			tau_q   <= RST_TAU;
			dist_q  <= RST_DIST;
			ratio_q <= RST_RATIO;
			vmin_q  <= RST_VMIN;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_YMAX:  ymax_q  <= cfg_wdata[30:0];
				REG_TAU:   tau_q   <= cfg_wdata[30:0];
				REG_DIST:  dist_q  <= cfg_wdata[30:0];
				REG_RATIO: ratio_q <= cfg_wdata[30:0];
				REG_VMIN:  vmin_q  <= signed'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// zero in a strictly positive register acts as one lsb
	assign ymax_e  = (ymax_q == '0) ? 31'd1 : ymax_q;
	assign tau_e   = (tau_q == '0) ? 31'd1 : tau_q;
	assign ratio_e = (ratio_q == '0) ? 31'd1 : ratio_q;
	assign den3    = {2'b00, tau_e} + {1'b0, tau_e, 1'b0};

	// valid chain and busy
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			busy_q <= 1'b1;
		end else begin
			vld_q  <= {vld_q[PIPE_DEPTH-2:0], start & ~busy_q};
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign done = vld_q[PIPE_DEPTH-1];

	// s1: input capture
	logic signed [31:0] req_s1, cur_s1, up_s1, dev_s1;

	always_ff @(posedge clk) begin
		req_s1 <= requested_speed;
		cur_s1 <= present_curvature;
		up_s1  <= upcoming_curvature;
		dev_s1 <= lateral_deviation;
	end

	// s2: magnitudes and apply flags
	logic [32:0]        dk;
	logic [32:0]        mag_s2;
	logic [31:0]        ay_s2;
	logic               kf_s2, yf_s2;
	logic signed [31:0] req_s2;

	assign dk = {up_s1[31], up_s1} - {cur_s1[31], cur_s1};

	always_ff @(posedge clk) begin
		mag_s2 <= dk[32] ? 33'(33'd0 - dk) : dk;
		ay_s2  <= dev_s1[31] ? 32'(32'd0 - dev_s1) : dev_s1;
		kf_s2  <= dk != '0;
		yf_s2  <= dev_s1 != '0;
		req_s2 <= req_s1;
	end

	// curvature branch: ymax << 3F / (tau |dk|), then root
	logic [63:0]      den_w, den_s3;
	logic [NXW-1:0]   nx;
	logic [TOPW-1:0]  top;
	logic             sat_s4;
	logic [63:0]      rem_s4, den_s4;
	logic [61:0]      lo_s4;
	logic [61:0]      q1, sq_in;
	logic             sat_d;
	logic [30:0]      root;

	assign den_w = tau_e * mag_s2;
	assign nx    = NXW'(ymax_e) << (3 * F);
	assign top   = nx[NXW-1:62];

	always_ff @(posedge clk) begin
		den_s3 <= den_w;
		// quotient of 2^62 or more saturates
		sat_s4 <= 65'(top) >= 65'(den_s3);
		rem_s4 <= 64'(top);
		lo_s4  <= nx[61:0];
		den_s4 <= den_s3;
	end

	csl_divu #(.QW(62), .DW(64)) u_div_curv (
		.clk    (clk),
		.rem_in (rem_s4),
		.num_in (lo_s4),
		.den_in (den_s4),
		.quot   (q1)
	);

	csl_delay #(.WIDTH(1), .DEPTH(62)) u_dly_sat (
		.clk  (clk),
		.din  (sat_s4),
		.dout (sat_d)
	);

	assign sq_in = sat_d ? '1 : q1;

	csl_isqrt u_root (
		.clk  (clk),
		.val  (sq_in),
		.root (root)
	);

	// deviation branch: log term
	logic [LOG_FRAC+4:0] lg_y, lg_d;
	logic [LOG_FRAC+5:0] diff;
	logic [32:0]         dmag_s33;
	logic                dneg_s33;
	logic [62:0]         prod_w, prod_s34;
	logic                dneg_s34;
	logic [QA-1:0]       qa, qa_j;
	logic [62:0]         prod_j;
	logic                dneg_j;

	csl_log2 u_log_ymax (
		.clk (clk),
		.x   (32'(ymax_e)),
		.lg  (lg_y)
	);

	csl_log2 u_log_dev (
		.clk (clk),
		.x   (ay_s2),
		.lg  (lg_d)
	);

	assign diff   = {1'b0, lg_y} - {1'b0, lg_d};
	assign prod_w = dmag_s33 * K_LN2_THIRD;

	always_ff @(posedge clk) begin
		dneg_s33 <= diff[LOG_FRAC+5];
		dmag_s33 <= diff[LOG_FRAC+5] ? 33'(34'd0 - diff) : diff[32:0];
		prod_s34 <= prod_w;
		dneg_s34 <= dneg_s33;
	end

	// (n + 1) / n as 2^F + 2^2F / n
	csl_divu #(.QW(QA), .DW(31)) u_div_ratio (
		.clk    (clk),
		.rem_in (31'd0),
		.num_in (A_NUM),
		.den_in (ratio_e),
		.quot   (qa)
	);

	csl_delay #(.WIDTH(64), .DEPTH(LAT_J - LOGK_LAT)) u_dly_term (
		.clk  (clk),
		.din  ({dneg_s34, prod_s34}),
		.dout ({dneg_j, prod_j})
	);

	csl_delay #(.WIDTH(QA), .DEPTH(LAT_J - QA)) u_dly_ratio (
		.clk  (clk),
		.din  (qa),
		.dout (qa_j)
	);

	// deviation branch: d |S| / (3 tau)
	logic [AW-1:0]      a_val, t_val;
	logic [AW-1:0]      smag_sj1;
	logic               sneg_sj1;
	logic [30+HALF:0]   plo_w, phi_w, plo_sj2, phi_sj2;
	logic               sneg_sj2;
	logic [PW-1:0]      p_sj3;
	logic               sneg_sj3;
	logic [HW-1:0]      hi;
	logic [32:0]        rem2_sj4;
	logic [31:0]        lo2_sj4;
	logic               big_sj4, sneg_sj4;
	logic [31:0]        q2;
	logic               big_d, sneg_d;
	logic [32:0]        qc;
	logic signed [31:0] lim2_sj5;

	assign a_val = AW'(qa_j) + (AW'(1) << F);
	assign t_val = AW'(TW'(prod_j >> (60 - F)));
	assign plo_w = dist_q * smag_sj1[HALF-1:0];
	assign phi_w = dist_q * smag_sj1[AW-1:HALF];
	assign hi    = HW'(p_sj3 >> 32);

	always_ff @(posedge clk) begin
		if (!dneg_j) begin
			smag_sj1 <= a_val + t_val;
			sneg_sj1 <= 1'b0;
		end else if (t_val > a_val) begin
			smag_sj1 <= t_val - a_val;
			sneg_sj1 <= 1'b1;
		end else begin
			smag_sj1 <= a_val - t_val;
			sneg_sj1 <= 1'b0;
		end
		plo_sj2  <= plo_w;
		phi_sj2  <= phi_w;
		sneg_sj2 <= sneg_sj1;
		p_sj3    <= PW'(plo_sj2) + (PW'(phi_sj2) << HALF);
		sneg_sj3 <= sneg_sj2;
		// quotient of 2^32 or more is past the cap anyway
		big_sj4  <= hi >= HW'(den3);
		rem2_sj4 <= hi[32:0];
		lo2_sj4  <= p_sj3[31:0];
		sneg_sj4 <= sneg_sj3;
	end

	csl_divu #(.QW(32), .DW(33)) u_div_dev (
		.clk    (clk),
		.rem_in (rem2_sj4),
		.num_in (lo2_sj4),
		.den_in (den3),
		.quot   (q2)
	);

	csl_delay #(.WIDTH(2), .DEPTH(32)) u_dly_dev_flags (
		.clk  (clk),
		.din  ({big_sj4, sneg_sj4}),
		.dout ({big_d, sneg_d})
	);

	assign qc = (big_d || ({1'b0, q2} > Q2_CAP)) ? Q2_CAP : {1'b0, q2};

	always_ff @(posedge clk) begin
		if (sneg_d) begin
			lim2_sj5 <= signed'(32'(33'd0 - qc));
		end else begin
			lim2_sj5 <= qc[31] ? 32'sh7FFF_FFFF : signed'(qc[31:0]);
		end
	end

	// line up with the curvature branch
	logic signed [31:0] lim2_al;
	logic [33:0]        side_al;
	logic signed [31:0] req_al, lim1, r;
	logic               kf_al, yf_al;
	logic signed [31:0] limited_q;

	csl_delay #(.WIDTH(32), .DEPTH(CURV_LAT - DEV_LAT)) u_dly_lim2 (
		.clk  (clk),
		.din  (lim2_sj5),
		.dout (lim2_al)
	);

	csl_delay #(.WIDTH(34), .DEPTH(CURV_LAT)) u_dly_side (
		.clk  (clk),
		.din  ({req_s2, kf_s2, yf_s2}),
		.dout (side_al)
	);

	assign req_al = signed'(side_al[33:2]);
	assign kf_al  = side_al[1];
	assign yf_al  = side_al[0];
	assign lim1   = signed'({1'b0, root});

	always_comb begin
		r = req_al;
		if (kf_al && (lim1 < r)) begin
			r = lim1;
		end
		if (yf_al && (lim2_al < r)) begin
			r = lim2_al;
		end
		if (vmin_q > r) begin
			r = vmin_q;
		end
	end

	always_ff @(posedge clk) begin
		limited_q <= r;
	end

	assign limited_speed = limited_q;

`ifndef SYNTHESIS
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_DEPTH))
		else $error("done without a word taken at the pipeline depth");

	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (limited_speed >= vmin_q))
		else $error("result below minimum speed");

	a_not_above_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((limited_speed <= $past(requested_speed, PIPE_DEPTH)) ||
		          (limited_speed == vmin_q)))
		else $error("result above request and not at minimum speed");
`endif

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the curvature speed limiter.
module testbench;
	import csl_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam logic [63:0] CURV_CAP = (64'd1 << 62) - 64'd1;
	localparam logic [63:0] DEV_CAP = 64'd1 << 31;

	class speed_scoreboard;
		logic [30:0] ymax_r, tau_r, dist_r, ratio_r;
		logic signed [31:0] vmin_r;
		logic [31:0] expected_speeds[$];
		int errors;

		function new();
			ymax_r = RST_YMAX;
			tau_r = RST_TAU;
			dist_r = RST_DIST;
			ratio_r = RST_RATIO;
			vmin_r = RST_VMIN;
			errors = 0;
		endfunction

		function void set_register(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_YMAX: ymax_r = data[30:0];
				REG_TAU: tau_r = data[30:0];
				REG_DIST: dist_r = data[30:0];
				REG_RATIO: ratio_r = data[30:0];
				REG_VMIN: vmin_r = data;
				default: ;
			endcase
		endfunction

		// log2 with 28 fraction bits by repeated squaring, truncated
		function logic [63:0] log2_q28(logic [63:0] x);
			int e;
			logic [63:0] m, r, sq;
			e = 31;
			while (e > 0 && x[e] == 1'b0)
				e--;
			m = x << (31 - e);
			r = 64'(e);
			for (int i = 0; i < LOG_FRAC; i++) begin
				sq = m * m;
				r = r << 1;
				if (sq[63]) begin
					r[0] = 1'b1;
					m = sq >> 32;
				end else begin
					m = sq >> 31;
				end
			end
			return r;
		endfunction

		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic [31:0] limit_speed(logic signed [31:0] req, logic signed [31:0] cur,
				logic signed [31:0] up, logic signed [31:0] y);
			longint r, dk, dl, term, a, s, lim;
			logic [63:0] ymx, tu, nn, mag, ay, dmag, tmag, smag, q;
			logic [127:0] qq;
			ymx = (ymax_r == 0) ? 64'd1 : 64'(ymax_r);
			tu = (tau_r == 0) ? 64'd1 : 64'(tau_r);
			nn = (ratio_r == 0) ? 64'd1 : 64'(ratio_r);
			r = longint'(req);
			dk = longint'(up) - longint'(cur);
			if (dk != 0) begin
				mag = (dk < 0) ? -dk : dk;
				qq = (128'(ymx) << (3 * FB)) / (128'(tu) * 128'(mag));
				q = (qq > 128'(CURV_CAP)) ? CURV_CAP : qq[63:0];
				lim = longint'(int_sqrt(q));
				if (lim < r)
					r = lim;
			end
			if (y != 0) begin
				ay = (y < 0) ? -longint'(y) : longint'(y);
				dl = longint'(log2_q28(ymx)) - longint'(log2_q28(ay));
				dmag = (dl < 0) ? -dl : dl;
				qq = (128'(dmag) * 128'(K_LN2_THIRD)) >> (60 - FB);
				tmag = qq[63:0];
				term = (dl < 0) ? -longint'(tmag) : longint'(tmag);
				a = (longint'(1) << FB) + longint'((64'd1 << (2 * FB)) / nn);
				s = a + term;
				smag = (s < 0) ? -s : s;
				qq = (128'(dist_r) * 128'(smag)) / (128'd3 * 128'(tu));
				q = (qq > 128'(DEV_CAP)) ? DEV_CAP : qq[63:0];
				lim = (s < 0) ? -longint'(q) : longint'(q);
				if (lim > 64'sh7FFFFFFF)
					lim = 64'sh7FFFFFFF;
				if (lim < r)
					r = lim;
			end
			if (longint'(vmin_r) > r)
				r = longint'(vmin_r);
			return r[31:0];
		endfunction

		function void note_sample(logic signed [31:0] req, logic signed [31:0] cur,
				logic signed [31:0] up, logic signed [31:0] y);
			expected_speeds.push_back(limit_speed(req, cur, up, y));
		endfunction

		function void check_speed(logic [31:0] actual);
			logic [31:0] want;
			if (expected_speeds.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual %h", $time, actual);
				errors++;
				return;
			end
			want = expected_speeds.pop_front();
			if (want !== actual) begin
				$display("%0t: limited_speed mismatch, expected %h, actual %h",
					$time, want, actual);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [31:0] requested_speed = '0;
	logic signed [31:0] present_curvature = '0;
	logic signed [31:0] upcoming_curvature = '0;
	logic signed [31:0] lateral_deviation = '0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_wdata = '0;
	logic signed [31:0] limited_speed;

	speed_scoreboard sb = new();
	int idle_pct;

	always #5 clk = ~clk;

	curvature_speed_limiter i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.requested_speed(requested_speed), .present_curvature(present_curvature),
		.upcoming_curvature(upcoming_curvature), .lateral_deviation(lateral_deviation),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.done(done), .limited_speed(limited_speed)
	);

	// values seen here are those before the edge
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_sample(requested_speed, present_curvature, upcoming_curvature,
				lateral_deviation);
		if (arst_n && done)
			sb.check_speed(limited_speed);
	end

	function automatic logic [31:0] rand_word();
		logic [31:0] v;
		case ($urandom_range(5))
			0: v = $urandom;
			1: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1))
					v = -v;
			end
			2: v = 0;
			3: case ($urandom_range(3))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'd1;
				default: v = 32'hFFFF_FFFF;
			endcase
			default: begin
				v = $urandom_range(200000);
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	task automatic send_word(logic [31:0] req, logic [31:0] cur, logic [31:0] up,
			logic [31:0] y);
		start <= 1'b1;
		requested_speed <= req;
		present_curvature <= cur;
		upcoming_curvature <= up;
		lateral_deviation <= y;
		do @(posedge clk); while (busy);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
	endtask

	task automatic send_random(int count);
		logic [31:0] cur, up, y;
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0)
				idle_pct = (i / 40) % 3 == 0 ? 0 : ((i / 40) % 3 == 1 ? 80 : 35);
			cur = rand_word();
			up = $urandom_range(2) ? cur + ($urandom >> $urandom_range(16, 31)) : rand_word();
			y = rand_word();
			send_word(rand_word(), cur, up, y);
		end
	endtask

	// registers only change once the pipe has drained
	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		start <= 1'b0;
		while (sb.expected_speeds.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
	endtask

	task automatic write_all(logic [31:0] ym, logic [31:0] tu, logic [31:0] di,
			logic [31:0] ra, logic [31:0] vm);
		write_reg(REG_YMAX, ym);
		write_reg(REG_TAU, tu);
		write_reg(REG_DIST, di);
		write_reg(REG_RATIO, ra);
		write_reg(REG_VMIN, vm);
	endtask

	function automatic logic [31:0] rand_reg();
		return $urandom >> $urandom_range(31);
	endfunction

	initial begin
		idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero difference, zero deviation, ymax equal to |y|
		send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
		send_word(32'h0005_0000, 32'd1000, 32'd1000, 32'd32768);
		send_word(32'h0005_0000, 32'd0, 32'd1, 32'd1);
		send_word(32'h0005_0000, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h7FFF_FFFF, 32'd0, 32'd65536, 32'hFFFF_8000);
		send_word(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0100_0000);
		send_word(32'hFFFF_FFFF, 32'd5, 32'd5, 32'd3);
		send_word(32'd0, 32'h4000_0000, 32'hC000_0000, 32'd0);
		send_word(32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_random(140);

		write_all(32'hFFFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 32'h8000_0000);
		write_reg(REG_UNUSED, 32'h1234_5678);
		send_word(32'h8000_0000, 32'd0, 32'd1, 32'd1);
		send_word(32'h7FFF_FFFF, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_word(32'h0001_0000, 32'd0, 32'd0, 32'h8000_0000);
		send_random(140);

		write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
		send_word(32'h8000_0000, 32'd0, 32'd1, 32'd1);
		send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_random(60);

		write_all(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_0000);
		send_random(140);

		for (int p = 0; p < 4; p++) begin
			write_all(rand_reg() | ($urandom_range(1) << 31), rand_reg(), rand_reg(),
				rand_reg(), rand_word());
			send_random(120);
		end
		start <= 1'b0;

		while (sb.expected_speeds.size() != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.expected_speeds.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
